/* sv/rational_arithmetic_unit_assert.svh */
// Assertion macros for the rational arithmetic unit checker
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

/* sv/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DEN,
    ST_MUL_A,
    ST_MUL_B,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_OUT
  } state_t;

endpackage

/* sv/rau_mul.sv */
`timescale 1ns / 1ps
module rau_mul #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  output logic                 done,
  output logic [WORD_BITS-1:0] prod
);

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] a_r, b_r, acc_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + (b_r[0] ? a_r : '0);
      a_r   <= {a_r[WORD_BITS-2:0], 1'b0};
      b_r   <= {1'b0, b_r[WORD_BITS-1:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

/* sv/rau_gcd.sv */
`timescale 1ns / 1ps
module rau_gcd #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_x,
  input  logic [WORD_BITS-1:0] op_y,
  output logic                 done,
  output logic [WORD_BITS-1:0] gcd
);

  localparam int KW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] x_r, y_r, g_r;
  logic [KW-1:0]        k_r;
  logic                 busy_r, done_r;
  logic                 fin;

  assign fin = (x_r == '0) || (y_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && fin) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= op_x;
      y_r <= op_y;
      k_r <= '0;
    end else if (busy_r) begin
      if (fin) begin
        g_r <= (x_r | y_r) << k_r;
      end else if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= x_r - y_r;
      end else begin
        y_r <= y_r - x_r;
      end
    end
  end

  assign done = done_r;
  assign gcd  = g_r;

endmodule

/* sv/rau_div.sv */
`timescale 1ns / 1ps
module rau_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quot
);

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] n_r, d_r, rem_r, q_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;
  logic [WORD_BITS:0]   sh, diff;
  logic                 take;

  assign sh   = {rem_r, n_r[WORD_BITS-1]};
  assign diff = sh - {1'b0, d_r};
  assign take = sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[WORD_BITS-1:0] : sh[WORD_BITS-1:0];
      q_r   <= {q_r[WORD_BITS-2:0], take};
      n_r   <= {n_r[WORD_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* sv/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall  | command, a_num, a_den, b_num, b_den
// out_    | output    | out_valid / out_stall| res_num, res_den, den_zero
// One transfer in at a time; in_stall stays high until the result is taken.
// Each item runs 2 or 3 serial multiplies (3 for add and sub), a binary gcd,
// and two serial divides by the gcd when the gcd exceeds one.
// Reset is synchronous; the output register holds its value while out_stall.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic signed [WORD_BITS-1:0] in_a_num,
  input  logic [WORD_BITS-1:0]        in_a_den,
  input  logic signed [WORD_BITS-1:0] in_b_num,
  input  logic [WORD_BITS-1:0]        in_b_den,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_res_num,
  output logic [WORD_BITS-1:0]        out_res_den,
  output logic                        out_den_zero
);

  rau_pkg::state_t state_r, state_nxt;
  logic            launch_r;

  logic [WORD_BITS-1:0] an_r, ad_r, bn_r, bd_r;
  logic                 add_r;
  logic [WORD_BITS-1:0] num_r, den_r, mag, res_mag_r, res_den_r;

  logic [WORD_BITS-1:0] a_u, b_u, bn_eff, bd_eff;
  logic                 bneg;

  logic                 mul_start, mul_done;
  logic [WORD_BITS-1:0] mul_a, mul_b, mul_p;
  logic                 gcd_start, gcd_done;
  logic [WORD_BITS-1:0] gcd_g;
  logic                 div_start, div_done;
  logic [WORD_BITS-1:0] div_n, div_q;

  assign a_u  = $unsigned(in_a_num);
  assign b_u  = $unsigned(in_b_num);
  assign bneg = b_u[WORD_BITS-1];

  always_comb begin
    bn_eff = b_u;
    bd_eff = in_b_den;
    case (in_command)
      rau_pkg::CMD_SUB: bn_eff = -b_u;
      rau_pkg::CMD_DIV: begin
        bn_eff = bneg ? -in_b_den : in_b_den;
        bd_eff = bneg ? -b_u : b_u;
      end
      default: ;
    endcase
  end

  assign mag = num_r[WORD_BITS-1] ? -num_r : num_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::ST_IDLE:    if (in_valid) state_nxt = rau_pkg::ST_MUL_DEN;
      rau_pkg::ST_MUL_DEN: if (mul_done) state_nxt = rau_pkg::ST_MUL_A;
      rau_pkg::ST_MUL_A: begin
        if (mul_done) state_nxt = add_r ? rau_pkg::ST_MUL_B : rau_pkg::ST_GCD;
      end
      rau_pkg::ST_MUL_B:   if (mul_done) state_nxt = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD: begin
        if (gcd_done) begin
          state_nxt = (gcd_g > WORD_BITS'(1)) ? rau_pkg::ST_DIV_NUM : rau_pkg::ST_OUT;
        end
      end
      rau_pkg::ST_DIV_NUM: if (div_done) state_nxt = rau_pkg::ST_DIV_DEN;
      rau_pkg::ST_DIV_DEN: if (div_done) state_nxt = rau_pkg::ST_OUT;
      rau_pkg::ST_OUT:     if (!out_stall) state_nxt = rau_pkg::ST_IDLE;
      default:             state_nxt = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    gcd_start = 1'b0;
    div_start = 1'b0;
    mul_a     = ad_r;
    mul_b     = bd_r;
    div_n     = res_mag_r;
    case (state_r)
      rau_pkg::ST_MUL_DEN: mul_start = launch_r;
      rau_pkg::ST_MUL_A: begin
        mul_start = launch_r;
        mul_a     = an_r;
        mul_b     = add_r ? bd_r : bn_r;
      end
      rau_pkg::ST_MUL_B: begin
        mul_start = launch_r;
        mul_a     = bn_r;
        mul_b     = ad_r;
      end
      rau_pkg::ST_GCD:     gcd_start = launch_r;
      rau_pkg::ST_DIV_NUM: div_start = launch_r;
      rau_pkg::ST_DIV_DEN: begin
        div_start = launch_r;
        div_n     = res_den_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rau_pkg::ST_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= (state_nxt != state_r);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::ST_IDLE: begin
        if (in_valid) begin
          an_r  <= a_u;
          ad_r  <= in_a_den;
          bn_r  <= bn_eff;
          bd_r  <= bd_eff;
          add_r <= in_command inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB};
        end
      end
      rau_pkg::ST_MUL_DEN: if (mul_done) den_r <= mul_p;
      rau_pkg::ST_MUL_A:   if (mul_done) num_r <= mul_p;
      rau_pkg::ST_MUL_B:   if (mul_done) num_r <= num_r + mul_p;
      rau_pkg::ST_GCD: begin
        if (gcd_done) begin
          res_mag_r <= mag;
          res_den_r <= den_r;
        end
      end
      rau_pkg::ST_DIV_NUM: if (div_done) res_mag_r <= div_q;
      rau_pkg::ST_DIV_DEN: if (div_done) res_den_r <= div_q;
      default: ;
    endcase
  end

  rau_mul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  rau_gcd #(.WORD_BITS(WORD_BITS)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .op_x  (mag),
    .op_y  (den_r),
    .done  (gcd_done),
    .gcd   (gcd_g)
  );

  rau_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (gcd_g),
    .done     (div_done),
    .quot     (div_q)
  );

  assign in_stall     = (state_r != rau_pkg::ST_IDLE);
  assign out_valid    = (state_r == rau_pkg::ST_OUT);
  assign out_res_num  = $signed(num_r[WORD_BITS-1] ? -res_mag_r : res_mag_r);
  assign out_res_den  = res_den_r;
  assign out_den_zero = (res_den_r == '0);

endmodule

/* sv/rau_check.sv */
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_assert.svh"
module rau_check #(
  parameter int WORD_BITS = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [WORD_BITS-1:0] out_res_num,
  input logic [WORD_BITS-1:0]        out_res_den,
  input logic                        out_den_zero
);

  `RAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_res_num))
  `RAU_ASSERT_NOW(a_busy_out, out_valid, in_stall)
  `RAU_ASSERT_NEXT(a_busy_accept, in_valid && !in_stall, in_stall && !out_valid)
  `RAU_ASSERT_NOW(a_den_flag, out_valid, out_den_zero == (out_res_den == '0))

endmodule

bind rational_arithmetic_unit rau_check #(.WORD_BITS(WORD_BITS)) u_rau_check (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int W = 32;
  localparam int LIMIT = 4_000_000;

  typedef struct {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         dz;
  } frac_t;

  class frac_scoreboard;
    frac_t pending[$];
    int    errors;

    static function logic [W-1:0] euclid(logic [W-1:0] x, logic [W-1:0] y);
      logic [W-1:0] r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    static function frac_t compute(logic [1:0] cmd, logic [W-1:0] an, logic [W-1:0] ad,
                                   logic [W-1:0] bn, logic [W-1:0] bd);
      frac_t        f;
      logic [W-1:0] rn, rd, mag, g, tn, td;
      logic         neg;
      if (cmd == rau_pkg::CMD_DIV) begin
        neg = bn[W-1];
        tn = neg ? -bd : bd;
        td = neg ? -bn : bn;
        bn = tn;
        bd = td;
        cmd = rau_pkg::CMD_MUL;
      end
      if (cmd == rau_pkg::CMD_SUB) begin
        bn = -bn;
        cmd = rau_pkg::CMD_ADD;
      end
      rd = ad * bd;
      if (cmd == rau_pkg::CMD_ADD) rn = an * bd + bn * ad;
      else rn = an * bn;
      neg = rn[W-1];
      mag = neg ? -rn : rn;
      g = euclid(mag, rd);
      while (g > 1) begin
        mag = mag / g;
        rd = rd / g;
        g = euclid(mag, rd);
      end
      f.num = neg ? -mag : mag;
      f.den = rd;
      f.dz = (rd == 0);
      return f;
    endfunction

    function void note_operands(logic [1:0] cmd, logic [W-1:0] an, logic [W-1:0] ad,
                                logic [W-1:0] bn, logic [W-1:0] bd);
      pending.push_back(compute(cmd, an, ad, bn, bd));
    endfunction

    function void check_result(logic [W-1:0] n, logic [W-1:0] d, logic dz);
      frac_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %0d/%0d", $time, $signed(n), d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (n !== e.num) begin
        $display("%0t res_num expected %0d actual %0d", $time, $signed(e.num), $signed(n));
        errors++;
      end
      if (d !== e.den) begin
        $display("%0t res_den expected %0d actual %0d", $time, e.den, d);
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t den_zero expected %0b actual %0b", $time, e.dz, dz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_command = rau_pkg::CMD_ADD;
  logic signed [W-1:0] in_a_num = 0, in_b_num = 0;
  logic [W-1:0] in_a_den = 1, in_b_den = 1;
  logic out_valid;
  logic out_stall = 0;
  logic signed [W-1:0] out_res_num;
  logic [W-1:0] out_res_den;
  logic out_den_zero;

  frac_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int cycles = 0;
  int sent = 0;
  int seen = 0;

  rational_arithmetic_unit #(.WORD_BITS(W)) u_top (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_res_num, out_res_den, out_den_zero);
      seen <= seen + 1;
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send(logic [1:0] cmd, logic [W-1:0] an, logic [W-1:0] ad,
                      logic [W-1:0] bn, logic [W-1:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_operands(cmd, an, ad, bn, bd);
    sent++;
  endtask

  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom_range(9);
      1: return -$urandom_range(9);
      2: return $urandom_range(1000);
      3: return {1'b1, {(W-1){1'b0}}} + $urandom_range(3);
      4: return {W{1'b1}} - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] pick_den();
    logic [W-1:0] d;
    d = pick_word();
    if (d == 0 && $urandom_range(9) != 0) d = 1;
    return d;
  endfunction

  task automatic random_block(int count);
    logic [1:0] cmd;
    logic [W-1:0] an, bn, k;
    for (int i = 0; i < count; i++) begin
      cmd = 2'($urandom_range(3));
      an = pick_word();
      bn = pick_word();
      if ($urandom_range(7) == 0) bn = 0;
      send(cmd, an, pick_den(), bn, pick_den());
      if ($urandom_range(9) == 0) begin
        k = $urandom_range(1, 50);
        send(cmd, an * k, k * 6, bn * k, k * 4);
      end
    end
  endtask

  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ALL1 = {W{1'b1}};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(rau_pkg::CMD_ADD, 1, 2, 1, 3);
    send(rau_pkg::CMD_SUB, 1, 2, 1, 2);
    send(rau_pkg::CMD_MUL, 3, 4, -8, 9);
    send(rau_pkg::CMD_DIV, 3, 4, -8, 9);
    send(rau_pkg::CMD_DIV, 5, 7, 0, 3);
    send(rau_pkg::CMD_DIV, 0, 7, 0, 3);
    send(rau_pkg::CMD_DIV, -5, 7, 0, 3);
    send(rau_pkg::CMD_ADD, MAXP, 1, MAXP, 1);
    send(rau_pkg::CMD_SUB, MINN, 1, 1, 1);
    send(rau_pkg::CMD_MUL, MINN, 1, 1, 1);
    send(rau_pkg::CMD_MUL, MINN, 2, -1, 1);
    send(rau_pkg::CMD_DIV, MINN, ALL1, MINN, ALL1);
    send(rau_pkg::CMD_MUL, 1, 32'h10000, 1, 32'h10000);
    send(rau_pkg::CMD_ADD, 0, ALL1, 0, ALL1);
    send(rau_pkg::CMD_ADD, 1, 0, 2, 0);
    send(rau_pkg::CMD_MUL, 0, 5, 7, 0);
    send(rau_pkg::CMD_SUB, ALL1, ALL1, ALL1, ALL1);
    send(rau_pkg::CMD_DIV, MAXP, 1, -1, ALL1);
    send(rau_pkg::CMD_ADD, 6, 4, 10, 4);
    send(rau_pkg::CMD_MUL, 12, 35, 14, 18);

    random_block(250);
    send_idle_pct = 57;
    random_block(250);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    random_block(250);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_block(250);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 3000;
    random_block(200);

    in_valid <= 0;
    while (seen < sent) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("tb: %0d fractions through add, sub, mul, div incl. zero divisors,", sent);
    $display("tb: wrap extremes and reducible pairs under varied idle and stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
